FILE: hdl/sliding_window_latency_stats_assert.svh
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_LATENCY_STATS_ASSERT_SVH
`define SLIDING_WINDOW_LATENCY_STATS_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SWLS_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("swls port check failed");

// next-cycle implication
`define SWLS_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("swls port check failed");

`endif

FILE: hdl/swls_pkg.sv
`timescale 1ns / 1ps
package swls_pkg;

  localparam int TW    = 48;
  localparam int LW    = 32;
  localparam int CFG_W = 20;

  localparam logic [CFG_W-1:0] WIN_RESET = 20'd1000;
  localparam logic [CFG_W-1:0] IVL_RESET = 20'd1000;
  localparam logic [24:0]      RATE_MAX  = 25'h1FFFFFF;

  localparam logic REG_WINDOW   = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  typedef struct packed {
    logic [TW-1:0] now_ms;
    logic [LW-1:0] latency_ms;
    logic          ok;
  } item_t;

  typedef struct packed {
    logic        report_valid;
    logic [8:0]  window_count;
    logic [24:0] rate_x100;
    logic [38:0] mean_latency_x100;
    logic [31:0] peak_latency;
    logic [31:0] valley_latency;
    logic [13:0] success_x100;
    logic        evicted_full;
  } result_t;

  // classified word handed from front to back
  typedef struct packed {
    item_t            item;
    logic [TW-1:0]    thr;
    logic [CFG_W-1:0] win;
  } job_t;

endpackage

FILE: hdl/swls_ram.sv
`timescale 1ns / 1ps
module swls_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/swls_div.sv
`timescale 1ns / 1ps
module swls_div #(
  parameter int NW = 48,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNW = $clog2(NW + 1);

  logic           busy;
  logic [CNW-1:0] cnt;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  den_r;
  logic [DW:0]    trial;

  // restoring divide, one quotient bit a cycle
  assign trial = {rem, quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNW'(NW);
        quo   <= num;
        rem   <= '0;
        den_r <= den;
      end else if (busy) begin
        if (trial >= {1'b0, den_r}) begin
          rem <= DW'(trial - {1'b0, den_r});
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hdl/swls_front.sv
`timescale 1ns / 1ps
module swls_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  swls_pkg::item_t              item,
  input  logic [swls_pkg::CFG_W-1:0]   window_ms,
  output logic                         job_valid,
  input  logic                         job_pop,
  output swls_pkg::job_t               job
);
  import swls_pkg::*;

  job_t             q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic [CFG_W-1:0] win_eff;
  job_t             job_in;
  logic             do_push;
  logic             do_pop;

  // zero window acts as one
  assign win_eff = (window_ms == '0) ? CFG_W'(1) : window_ms;

  always_comb begin
    job_in.item = item;
    job_in.win  = win_eff;
    if (item.now_ms >= TW'(win_eff)) begin
      job_in.thr = item.now_ms - TW'(win_eff);
    end else begin
      job_in.thr = '0;
    end
  end

  assign full      = (cnt == 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = job_pop && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= job_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

FILE: hdl/swls_back.sv
`timescale 1ns / 1ps
module swls_back #(
  parameter int RING_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  output logic                       job_pop,
  input  swls_pkg::job_t             job,
  input  logic [swls_pkg::CFG_W-1:0] report_interval_ms,
  output logic                       res_valid,
  input  logic                       res_pop,
  output swls_pkg::result_t          res
);
  import swls_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int SW = LW + CW;
  localparam int NW = SW + 7;
  localparam int EW = TW + LW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EVICT, S_WRITE, S_EXP_RD, S_EXP_CHK, S_RPT, S_DIV, S_SCAN, S_OUT
  } state_t;

  typedef enum logic [1:0] {DIV_RATE, DIV_MEAN, DIV_SUCC} div_sel_t;

  state_t        state;
  div_sel_t      div_sel;
  job_t          job_r;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] held;
  logic [SW-1:0] lsum;
  logic [CW-1:0] ssum;
  logic [TW-1:0] last_rpt;
  logic          evicted;
  logic          rep_valid;
  logic [24:0]   rate;
  logic [38:0]   mean;
  logic [13:0]   succ;
  logic [31:0]   peak;
  logic [31:0]   valley;
  logic [CW-1:0] scan_cnt;
  logic [AW-1:0] scan_ptr;
  logic          scan_pend;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [TW-1:0] rd_time;
  logic [LW-1:0] rd_lat;
  logic          rd_ok;

  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_num;
  logic [CFG_W-1:0] div_den;
  logic [NW-1:0] div_quo;

  logic [CW+16:0] rate_num;
  logic [NW-1:0]  mean_num;
  logic [CW+13:0] succ_num;
  logic           rpt_due;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ram_we    = (state == S_WRITE);
  assign ram_wdata = {job_r.item.now_ms, job_r.item.latency_ms, job_r.item.ok};
  assign ram_raddr = (state == S_SCAN) ? scan_ptr : head;
  assign {rd_time, rd_lat, rd_ok} = ram_rdata;

  swls_ram #(.W(EW), .D(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swls_div #(.NW(NW), .DW(CFG_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign job_pop  = (state == S_IDLE) && job_valid;
  assign rate_num = (CW+17)'(held) * 17'd100000;
  assign mean_num = NW'({lsum, 6'b0}) + NW'({lsum, 5'b0}) + NW'({lsum, 2'b0});
  assign succ_num = (CW+14)'(ssum) * 14'd10000;

  // time going backwards counts as zero elapsed
  always_comb begin
    if (job_r.item.now_ms >= last_rpt) begin
      rpt_due = (job_r.item.now_ms - last_rpt) >= TW'(report_interval_ms);
    end else begin
      rpt_due = (report_interval_ms == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_sel   <= DIV_RATE;
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      lsum      <= '0;
      ssum      <= '0;
      last_rpt  <= '0;
      res_valid <= 1'b0;
      div_start <= 1'b0;
      scan_pend <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            job_r     <= job;
            evicted   <= (held == CW'(RING_DEPTH));
            rep_valid <= 1'b0;
            rate      <= '0;
            mean      <= '0;
            succ      <= '0;
            peak      <= '0;
            valley    <= '0;
            state     <= (held == CW'(RING_DEPTH)) ? S_EVICT : S_WRITE;
          end
        end
        S_EVICT: begin
          lsum  <= lsum - SW'(rd_lat);
          ssum  <= ssum - CW'(rd_ok);
          head  <= ring_next(head);
          held  <= held - 1'b1;
          state <= S_WRITE;
        end
        S_WRITE: begin
          tail  <= ring_next(tail);
          held  <= held + 1'b1;
          lsum  <= lsum + SW'(job_r.item.latency_ms);
          ssum  <= ssum + CW'(job_r.item.ok);
          state <= S_EXP_RD;
        end
        S_EXP_RD: begin
          state <= S_EXP_CHK;
        end
        S_EXP_CHK: begin
          if (rd_time < job_r.thr) begin
            lsum  <= lsum - SW'(rd_lat);
            ssum  <= ssum - CW'(rd_ok);
            head  <= ring_next(head);
            held  <= held - 1'b1;
            state <= (held == CW'(1)) ? S_RPT : S_EXP_RD;
          end else begin
            state <= S_RPT;
          end
        end
        S_RPT: begin
          if (rpt_due) begin
            rep_valid <= 1'b1;
            last_rpt  <= job_r.item.now_ms;
            if (held != '0) begin
              valley    <= '1;
              div_num   <= NW'(rate_num);
              div_den   <= job_r.win;
              div_start <= 1'b1;
              div_sel   <= DIV_RATE;
              state     <= S_DIV;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            unique case (div_sel)
              DIV_RATE: begin
                rate      <= (div_quo > NW'(RATE_MAX)) ? RATE_MAX : div_quo[24:0];
                div_num   <= mean_num;
                div_den   <= CFG_W'(held);
                div_start <= 1'b1;
                div_sel   <= DIV_MEAN;
              end
              DIV_MEAN: begin
                mean      <= div_quo[38:0];
                div_num   <= NW'(succ_num);
                div_den   <= CFG_W'(held);
                div_start <= 1'b1;
                div_sel   <= DIV_SUCC;
              end
              DIV_SUCC: begin
                succ      <= div_quo[13:0];
                scan_ptr  <= head;
                scan_cnt  <= held;
                scan_pend <= 1'b0;
                state     <= S_SCAN;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_cnt != '0) begin
            scan_ptr  <= ring_next(scan_ptr);
            scan_cnt  <= scan_cnt - 1'b1;
            scan_pend <= 1'b1;
          end else begin
            scan_pend <= 1'b0;
          end
          if (scan_pend) begin
            if (rd_lat > peak) begin
              peak <= rd_lat;
            end
            if (rd_lat < valley) begin
              valley <= rd_lat;
            end
          end
          if (scan_cnt == '0 && !scan_pend) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid) begin
            res_valid             <= 1'b1;
            res.report_valid      <= rep_valid;
            res.window_count      <= 9'(held);
            res.rate_x100         <= rate;
            res.mean_latency_x100 <= mean;
            res.peak_latency      <= peak;
            res.valley_latency    <= valley;
            res.success_x100      <= succ;
            res.evicted_full      <= evicted;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: hdl/sliding_window_latency_stats.sv
`timescale 1ns / 1ps
// steps: accept, evict the oldest entry if the ring is full, write, then read and check the head
// and drop each expired entry; a due report on a non-empty window adds three serial divides of
// NW = 39+clog2(RING_DEPTH+1) bits (48 by default) and a scan over the ring memory read port
// the back takes a new word only once the last is done, plus any wait for the result register to drain
// a 2-word front queue and 1-word result register let both sides stall on their own
// reset (rst, synchronous): ring empty, sums and last report time zero, both registers 1000
module sliding_window_latency_stats #(
  parameter int RING_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  // input word queue
  input  logic              push,
  output logic              full,
  input  swls_pkg::item_t   item,
  // result word queue
  output logic              empty,
  input  logic              pop,
  output swls_pkg::result_t result,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import swls_pkg::*;

  logic [CFG_W-1:0] window_ms;
  logic [CFG_W-1:0] report_interval_ms;
  logic             job_valid;
  logic             job_pop;
  job_t             job;
  logic             res_valid;

  // register file: window at byte 0, report interval at byte 4
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms          <= WIN_RESET;
      report_interval_ms <= IVL_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WINDOW:   window_ms          <= pwdata[CFG_W-1:0];
        REG_INTERVAL: report_interval_ms <= pwdata[CFG_W-1:0];
        default:      window_ms          <= window_ms;
      endcase
    end
  end

  // read back the addressed register
  always_comb begin
    unique case (paddr[2])
      REG_WINDOW:   prdata = 32'(window_ms);
      REG_INTERVAL: prdata = 32'(report_interval_ms);
      default:      prdata = '0;
    endcase
  end

  // front: takes words, works out expiry threshold and effective window
  swls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .window_ms (window_ms),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  // back: ring update, expiry, report math, result register
  swls_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk                (clk),
    .rst                (rst),
    .job_valid          (job_valid),
    .job_pop            (job_pop),
    .job                (job),
    .report_interval_ms (report_interval_ms),
    .res_valid          (res_valid),
    .res_pop            (pop && res_valid),
    .res                (result)
  );

  assign empty = !res_valid;
endmodule

FILE: hdl/swls_chk.sv
`timescale 1ns / 1ps
`include "sliding_window_latency_stats_assert.svh"
module swls_chk (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input swls_pkg::result_t result,
  input logic              pready
);
  logic figs_zero;
  logic valley_ok;

  assign figs_zero = (result.rate_x100 == '0) && (result.mean_latency_x100 == '0) &&
                     (result.peak_latency == '0) && (result.valley_latency == '0) &&
                     (result.success_x100 == '0);
  assign valley_ok = (result.valley_latency <= result.peak_latency) && pready;

  // figures stay zero on a word without a report
  `SWLS_ASSERT_IMP(a_quiet_zero, !empty && !result.report_valid, figs_zero)
  // a report never shows a valley above its peak, and pready is high then
  `SWLS_ASSERT_IMP(a_valley_peak, !empty && result.report_valid, valley_ok)
  `SWLS_ASSERT_IMP(a_succ_range, !empty, result.success_x100 <= 14'd10000)
  `SWLS_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(result))
endmodule

bind sliding_window_latency_stats swls_chk u_swls_chk (.*);
